[rtl/cff_pkg.sv]
// shared types, constants and the crc byte update for the crc-32 frame finder
`default_nettype none

package cff_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1024;

  localparam int unsigned LEN_W     = 11;
  localparam int unsigned PAYLOAD_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [7:0]  ZERO_BYTE = 8'h00;

  localparam logic [LEN_W-1:0] HEAD_BYTES     = LEN_W'(6);
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = LEN_W'(10);
  localparam logic [LEN_W-1:0] TAIL_BYTES     = LEN_W'(4);
  localparam logic [LEN_W-1:0] MAX_LEN        = LEN_W'(MAX_FRAME_BYTES);

  localparam logic [LEN_W-1:0] POS_HEADER_HI = LEN_W'(1);
  localparam logic [LEN_W-1:0] POS_HEADER_LO = LEN_W'(2);
  localparam logic [LEN_W-1:0] POS_ADDRESS   = LEN_W'(4);
  localparam logic [LEN_W-1:0] POS_KIND      = LEN_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_WORD       = 3'd0,
    REG_OWN_ADDRESS       = 3'd1,
    REG_FIRST_FRAME_KIND  = 3'd2,
    REG_SECOND_FRAME_KIND = 3'd3,
    REG_MAX_PACKET_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_FOUND         = 2'd0,
    ST_HEADER_BAD    = 2'd1,
    ST_BUFFER_ENDED  = 2'd2,
    ST_LIMIT_PASSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0]      header_word;
    logic [7:0]       own_address;
    logic [7:0]       first_frame_kind;
    logic [7:0]       second_frame_kind;
    logic [LEN_W-1:0] max_packet_length;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic [LEN_W-1:0]     packet_length;
    logic [PAYLOAD_W-1:0] payload_length;
    logic [7:0]           frame_kind;
  } result_t;

  function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/cff_cfg_regs.sv]
// configuration register file of the crc-32 frame finder
`default_nettype none

module cff_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cff_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cff_pkg::cfg_t                         cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word       <= 16'd0;
      cfg.own_address       <= 8'd0;
      cfg.first_frame_kind  <= 8'd0;
      cfg.second_frame_kind <= 8'd1;
      cfg.max_packet_length <= cff_pkg::MAX_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cff_pkg::REG_HEADER_WORD:       cfg.header_word       <= cfg_data;
        cff_pkg::REG_OWN_ADDRESS:       cfg.own_address       <= cfg_data[7:0];
        cff_pkg::REG_FIRST_FRAME_KIND:  cfg.first_frame_kind  <= cfg_data[7:0];
        cff_pkg::REG_SECOND_FRAME_KIND: cfg.second_frame_kind <= cfg_data[7:0];
        cff_pkg::REG_MAX_PACKET_LENGTH:
          cfg.max_packet_length <= cfg_data[cff_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/cff_search.sv]
// search state and per-byte header, crc and limit checks
`default_nettype none

module cff_search (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_of_buffer,
  input  wire logic              last_of_buffer,
  input  wire cff_pkg::cfg_t     cfg,
  output logic                   res_valid,
  output cff_pkg::result_t       res
);

  logic [31:0]               running_crc;
  logic [7:0]                tail_window [4];
  logic [cff_pkg::LEN_W-1:0] byte_count;
  logic                      search_done;
  logic [7:0]                held_kind;

  logic                      active;
  logic [31:0]               crc_base;
  logic [7:0]                win_base [4];
  logic [cff_pkg::LEN_W-1:0] count_base;
  logic [7:0]                kind_base;
  logic [31:0]               running_crc_next;
  logic [7:0]                tail_window_next [4];
  logic [cff_pkg::LEN_W-1:0] byte_count_next;
  logic [7:0]                held_kind_next;
  logic [cff_pkg::LEN_W-1:0] limit;
  logic [31:0]               tail;
  logic                      head_ok;
  logic                      crc_match;
  cff_pkg::status_t          status_sel;
  logic [cff_pkg::LEN_W-1:0] payload_full;

  always_comb begin
    active     = first_of_buffer || !search_done;
    crc_base   = first_of_buffer ? cff_pkg::CRC_INIT : running_crc;
    count_base = first_of_buffer ? '0 : byte_count;
    kind_base  = first_of_buffer ? cff_pkg::ZERO_BYTE : held_kind;
    for (int i = 0; i < 4; i++) begin
      win_base[i] = first_of_buffer ? cff_pkg::ZERO_BYTE : tail_window[i];
    end

    running_crc_next = (count_base >= cff_pkg::TAIL_BYTES)
                       ? cff_pkg::crc_feed(crc_base, win_base[0]) : crc_base;
    tail_window_next[0] = win_base[1];
    tail_window_next[1] = win_base[2];
    tail_window_next[2] = win_base[3];
    tail_window_next[3] = data_byte;
    byte_count_next = count_base + cff_pkg::LEN_W'(1);

    limit = (cfg.max_packet_length < cff_pkg::MAX_LEN) ? cfg.max_packet_length
                                                       : cff_pkg::MAX_LEN;

    case (byte_count_next)
      cff_pkg::POS_HEADER_HI: head_ok = data_byte == cfg.header_word[15:8];
      cff_pkg::POS_HEADER_LO: head_ok = data_byte == cfg.header_word[7:0];
      cff_pkg::POS_ADDRESS:   head_ok = data_byte == cfg.own_address;
      cff_pkg::POS_KIND:      head_ok = data_byte == cfg.first_frame_kind ||
                                        data_byte == cfg.second_frame_kind;
      default:                head_ok = byte_count_next > cff_pkg::HEAD_BYTES ||
                                        data_byte == cff_pkg::ZERO_BYTE;
    endcase

    held_kind_next = (byte_count_next == cff_pkg::POS_KIND && head_ok)
                     ? data_byte : kind_base;

    tail = {tail_window_next[0], tail_window_next[1],
            tail_window_next[2], tail_window_next[3]};
    crc_match = byte_count_next >= cff_pkg::FRAME_OVERHEAD &&
                byte_count_next <= limit && ~running_crc_next == tail;

    res_valid  = 1'b1;
    status_sel = cff_pkg::ST_FOUND;
    if (!head_ok) begin
      status_sel = cff_pkg::ST_HEADER_BAD;
    end else if (crc_match) begin
      status_sel = cff_pkg::ST_FOUND;
    end else if (last_of_buffer) begin
      status_sel = cff_pkg::ST_BUFFER_ENDED;
    end else if (byte_count_next >= limit) begin
      status_sel = cff_pkg::ST_LIMIT_PASSED;
    end else begin
      res_valid = 1'b0;
    end
    res_valid = res_valid && active;

    payload_full = byte_count_next - cff_pkg::FRAME_OVERHEAD;
    res.status = status_sel;
    if (status_sel == cff_pkg::ST_FOUND) begin
      res.packet_length  = byte_count_next;
      res.payload_length = payload_full[cff_pkg::PAYLOAD_W-1:0];
      res.frame_kind     = held_kind_next;
    end else begin
      res.packet_length  = '0;
      res.payload_length = '0;
      res.frame_kind     = cff_pkg::ZERO_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= cff_pkg::CRC_INIT;
      byte_count  <= '0;
      search_done <= 1'b1;
      held_kind   <= cff_pkg::ZERO_BYTE;
      for (int i = 0; i < 4; i++) begin
        tail_window[i] <= cff_pkg::ZERO_BYTE;
      end
    end else if (step && active) begin
      running_crc <= running_crc_next;
      byte_count  <= byte_count_next;
      search_done <= res_valid;
      held_kind   <= held_kind_next;
      for (int i = 0; i < 4; i++) begin
        tail_window[i] <= tail_window_next[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/crc32_frame_finder_unit.sv]
// top level of the crc-32 frame finder: input register, search stage, result register
//
// bytes of a receive buffer enter on the input channel (in_valid, in_stall) with
// first and last marks; a first mark starts a new search for a crc-32 framed packet
// and at most one result item leaves on the output channel (out_valid, out_stall)
// per search: found, header mismatch, buffer ended or length limit passed
// one byte is taken every cycle while in_stall is low; a result appears on the output after
// the byte that causes it has passed the input register and then the result register,
// the two stages, with the byte-wide crc update and compare between them
// while a result waits under out_stall the input register still takes one byte,
// then in_stall rises until the result is taken
// configuration is written through cfg_valid, cfg_ready, cfg_index and cfg_data, always
// ready; the user must write it only while no byte is in flight, the block does not enforce it
// reset empties both stages, loads the register reset values and leaves the block
// ignoring bytes until the first byte with a first mark
`default_nettype none

module crc32_frame_finder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             first_of_buffer,
  input  wire logic                             last_of_buffer,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            status,
  output logic [cff_pkg::LEN_W-1:0]             packet_length,
  output logic [cff_pkg::PAYLOAD_W-1:0]         payload_length,
  output logic [7:0]                            frame_kind,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cff_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cff_pkg::cfg_t    cfg;
  cff_pkg::result_t res;
  cff_pkg::result_t out_item;
  logic             res_valid;
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_first;
  logic             hold_last;
  logic             advance;
  logic             step;

  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  cff_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cff_search u_search (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (hold_byte),
    .first_of_buffer (hold_first),
    .last_of_buffer  (hold_last),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .res             (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte  <= data_byte;
      hold_first <= first_of_buffer;
      hold_last  <= last_of_buffer;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_valid) begin
      out_item <= res;
    end
  end

  assign status         = out_item.status;
  assign packet_length  = out_item.packet_length;
  assign payload_length = out_item.payload_length;
  assign frame_kind     = out_item.frame_kind;

endmodule

`default_nettype wire
